FILE: rtl/core/container_unpack_crc_check_defines.svh
// Assertion shorthands for the checker file.
`ifndef CONTAINER_UNPACK_CRC_CHECK_DEFINES_SVH
`define CONTAINER_UNPACK_CRC_CHECK_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, quiet while i_rst_n is low
`define CUC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("container unpack check failed");

// Next-cycle implication, sampled on i_clk, quiet while i_rst_n is low
`define CUC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("container unpack check failed");

`endif

FILE: rtl/core/cuc_pkg.sv
`default_nettype none
package cuc_pkg;

    // Input transaction: one stream byte and its end marker
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_in_item;

    // Output transaction: one result per input byte
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic [2:0] status;
        logic       done_res;
    } t_out_item;

    // Status codes
    localparam logic [2:0] ST_BUSY    = 3'd0;
    localparam logic [2:0] ST_OK      = 3'd1;
    localparam logic [2:0] ST_BAD_SIG = 3'd2;
    localparam logic [2:0] ST_BAD_VER = 3'd3;
    localparam logic [2:0] ST_CRC_ERR = 3'd4;
    localparam logic [2:0] ST_TRUNC   = 3'd5;

    // CRC-32 constants (reflected form)
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

    // Classified byte, passed from the parser to the checking back end
    typedef struct packed {
        logic [7:0] data;
        logic       is_payload;
        logic       do_check;
        logic       do_reject;
        logic [2:0] code;
    } t_cmd;

    // Expected CRC as captured from the header
    typedef struct packed {
        logic        present;
        logic [31:0] expected;
    } t_chk_info;

    // Container signature, one byte per position
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h4F;
            3'd1:    v = 8'h54;
            3'd2:    v = 8'h49;
            3'd3:    v = 8'h4B;
            3'd4:    v = 8'h56;
            3'd5:    v = 8'h31;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/cuc_front.sv
`default_nettype none
module cuc_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_accept,
    input  cuc_pkg::t_in_item     i_item,
    output cuc_pkg::t_cmd         o_cmd,
    output cuc_pkg::t_chk_info    o_chk
);
    import cuc_pkg::*;

    localparam logic [3:0] PH_SIG     = 4'd0;
    localparam logic [3:0] PH_VMAJ    = 4'd1;
    localparam logic [3:0] PH_VMIN    = 4'd2;
    localparam logic [3:0] PH_COMP    = 4'd3;
    localparam logic [3:0] PH_PROT    = 4'd4;
    localparam logic [3:0] PH_SIZE    = 4'd5;
    localparam logic [3:0] PH_EXTRA   = 4'd6;
    localparam logic [3:0] PH_CRC     = 4'd7;
    localparam logic [3:0] PH_SKIP    = 4'd8;
    localparam logic [3:0] PH_PAYLOAD = 4'd9;
    localparam logic [3:0] PH_DONE    = 4'd10;

    logic [3:0]  r_phase, n_phase;
    logic [2:0]  r_idx, n_idx;
    logic [63:0] r_size, n_size;
    logic [31:0] r_extra, n_extra;
    logic [31:0] r_expected, n_expected;
    logic        r_present, n_present;

    logic [7:0]  b;
    logic [31:0] extra_full;
    logic [31:0] extra_less;
    logic [63:0] size_less;
    logic        v_check;
    logic        v_reject;
    logic [2:0]  v_code;

    assign b          = i_item.in_byte;
    assign extra_full = {b, r_extra[23:0]};
    assign extra_less = r_extra - 32'd4;
    assign size_less  = r_size - 64'd1;

    // Parse the header and classify each byte
    always_comb begin
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_size     = r_size;
        n_extra    = r_extra;
        n_expected = r_expected;
        n_present  = r_present;
        v_check    = 1'b0;
        v_reject   = 1'b0;
        v_code     = ST_BUSY;

        case (r_phase)
            PH_SIG: begin
                if (b != sig_byte(r_idx)) begin
                    v_reject = 1'b1;
                    v_code   = ST_BAD_SIG;
                end else if (r_idx == 3'd5) begin
                    n_idx   = 3'd0;
                    n_phase = PH_VMAJ;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            PH_VMAJ: begin
                if (b == 8'd0) begin
                    v_reject = 1'b1;
                    v_code   = ST_BAD_VER;
                end else begin
                    n_phase = PH_VMIN;
                end
            end
            PH_VMIN: begin
                n_idx   = 3'd0;
                n_phase = PH_COMP;
            end
            PH_COMP, PH_PROT: begin
                if (r_idx == 3'd1) begin
                    n_idx   = 3'd0;
                    n_phase = (r_phase == PH_COMP) ? PH_PROT : PH_SIZE;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            PH_SIZE: begin
                n_size[{r_idx, 3'b000} +: 8] = b;
                if (r_idx == 3'd7) begin
                    n_idx   = 3'd0;
                    n_phase = PH_EXTRA;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            PH_EXTRA: begin
                n_extra[{r_idx[1:0], 3'b000} +: 8] = b;
                if (r_idx == 3'd3) begin
                    n_idx = 3'd0;
                    if (extra_full >= 32'd4) begin
                        n_present = 1'b1;
                        n_phase   = PH_CRC;
                    end else if (extra_full != 32'd0) begin
                        n_phase = PH_SKIP;
                    end else if (r_size == 64'd0) begin
                        v_check = 1'b1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            PH_CRC: begin
                n_expected[{r_idx[1:0], 3'b000} +: 8] = b;
                if (r_idx == 3'd3) begin
                    n_idx   = 3'd0;
                    n_extra = extra_less;
                    if (extra_less != 32'd0) begin
                        n_phase = PH_SKIP;
                    end else if (r_size == 64'd0) begin
                        v_check = 1'b1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            PH_SKIP: begin
                n_extra = r_extra - 32'd1;
                if (r_extra == 32'd1) begin
                    if (r_size == 64'd0) begin
                        v_check = 1'b1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_size = size_less;
                if (size_less == 64'd0) begin
                    v_check = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // Close the stream on an end marker that the byte itself did not settle
        if (i_item.end_of_input && !v_check && !v_reject && (r_phase != PH_DONE)) begin
            if (n_phase == PH_PAYLOAD) begin
                v_check = 1'b1;
            end else begin
                v_reject = 1'b1;
                v_code   = ST_TRUNC;
            end
        end

        if (v_check || v_reject) begin
            n_phase = PH_DONE;
        end
    end

    // Hand the classified transaction to the queue
    always_comb begin
        o_cmd.data       = b;
        o_cmd.is_payload = (r_phase == PH_PAYLOAD);
        o_cmd.do_check   = v_check;
        o_cmd.do_reject  = v_reject;
        o_cmd.code       = v_code;
    end

    assign o_chk.present  = r_present;
    assign o_chk.expected = r_expected;

    // Advance the parser on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SIG;
            r_idx     <= 3'd0;
            r_present <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_idx     <= n_idx;
            r_present <= n_present;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_size     <= n_size;
            r_extra    <= n_extra;
            r_expected <= n_expected;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/cuc_queue.sv
`default_nettype none
module cuc_queue (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_push,
    input  cuc_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    input  wire           i_pop,
    output cuc_pkg::t_cmd o_cmd
);
    import cuc_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd];

    // Track fill level and pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // Store the entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/cuc_back.sv
`default_nettype none
module cuc_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_pop,
    input  cuc_pkg::t_cmd        i_cmd,
    input  cuc_pkg::t_chk_info   i_chk,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output cuc_pkg::t_out_item   o_out_data
);
    import cuc_pkg::*;

    logic [31:0] r_crc, n_crc;
    logic [2:0]  r_final, n_final;
    logic        r_done, n_done;
    logic        r_out_valid;
    t_out_item   r_out_data, n_out_data;

    // Reflected CRC-32 over one byte, one bit per step
    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] d);
        logic [31:0] c;
        c = c_in ^ {24'd0, d};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

    // Take from the queue whenever the output register is free or draining
    assign o_pop = i_valid && (!r_out_valid || !i_out_stall);

    // Update the CRC and settle the verdict
    always_comb begin
        n_crc   = i_cmd.is_payload ? crc_byte(r_crc, i_cmd.data) : r_crc;
        n_final = r_final;
        n_done  = r_done;
        if (i_cmd.do_reject) begin
            n_final = i_cmd.code;
            n_done  = 1'b1;
        end else if (i_cmd.do_check) begin
            n_final = (i_chk.present && ((n_crc ^ CRC_ONES) != i_chk.expected))
                      ? ST_CRC_ERR : ST_OK;
            n_done  = 1'b1;
        end
        n_out_data.out_byte  = i_cmd.is_payload ? i_cmd.data : 8'd0;
        n_out_data.out_valid = i_cmd.is_payload;
        n_out_data.status    = n_done ? n_final : ST_BUSY;
        n_out_data.done_res  = n_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= CRC_ONES;
            r_final     <= ST_BUSY;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_crc       <= n_crc;
            r_final     <= n_final;
            r_done      <= n_done;
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire

FILE: rtl/core/container_unpack_crc_check.sv
// Each accepted input transaction is stored in the queue, then registered in the output
// register, from which its result is offered until it is taken.
// Throughput: one transaction per cycle while i_out_stall is low; the CRC byte update,
// the 64-bit size count and the header parse each handle a whole byte at once.
// A two-entry queue parts the header parser from the CRC back end.
// Reset (i_rst_n low, synchronous): parser to signature phase, CRC to all ones,
// queue and output register emptied.
`default_nettype none
module container_unpack_crc_check (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  cuc_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output cuc_pkg::t_out_item  o_out_data
);
    import cuc_pkg::*;

    logic      accept;
    logic      q_full;
    logic      q_valid;
    logic      q_pop;
    t_cmd      f_cmd;
    t_cmd      q_cmd;
    t_chk_info chk;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    cuc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_data),
        .o_cmd    (f_cmd),
        .o_chk    (chk)
    );

    cuc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd)
    );

    cuc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .o_pop       (q_pop),
        .i_cmd       (q_cmd),
        .i_chk       (chk),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

FILE: rtl/core/cuc_checker.sv
`default_nettype none
`include "container_unpack_crc_check_defines.svh"
module cuc_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 o_in_stall,
    input cuc_pkg::t_in_item   i_in_data,
    input wire                 o_out_valid,
    input wire                 i_out_stall,
    input cuc_pkg::t_out_item  o_out_data
);
    import cuc_pkg::*;

    logic       in_acc;
    logic       out_acc;
    logic [2:0] r_pending;
    logic       r_seen_done;
    logic [2:0] r_last_status;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    // Count transactions in flight and remember the final verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending     <= 3'd0;
            r_seen_done   <= 1'b0;
            r_last_status <= ST_BUSY;
        end else begin
            r_pending <= r_pending + {2'd0, in_acc} - {2'd0, out_acc};
            if (out_acc && o_out_data.done_res) begin
                r_seen_done   <= 1'b1;
                r_last_status <= o_out_data.status;
            end
        end
    end

    `CUC_ASSERT_NOW(a_no_invented_result, out_acc, r_pending != 3'd0)
    `CUC_ASSERT_NOW(a_done_sticks, out_acc && r_seen_done, o_out_data.done_res && !o_out_data.out_valid)
    `CUC_ASSERT_NOW(a_verdict_holds, out_acc && r_seen_done, o_out_data.status == r_last_status)
    `CUC_ASSERT_NEXT(a_stalled_result_holds, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

endmodule

bind container_unpack_crc_check cuc_checker u_checker (.*);
`default_nettype wire
